// ----- rtl/two_digit_seven_segment_scanner_assert.svh -----
// Assertion macros shared by the scanner checker
`ifndef TWO_DIGIT_SEVEN_SEGMENT_SCANNER_ASSERT_SVH
`define TWO_DIGIT_SEVEN_SEGMENT_SCANNER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define TDSS_ASSERT_NOW(label, clk, rstn, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define TDSS_ASSERT_NEXT(label, clk, rstn, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (prop)) \
        else $error(msg);

// Next-cycle implication that is also checked across reset
`define TDSS_ASSERT_ALWAYS_NEXT(label, clk, cond, prop, msg) \
    label: assert property (@(posedge clk) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ----- rtl/tdss_pkg.sv -----
// Types, codes and constants of the two-digit seven-segment scanner
package tdss_pkg;

    localparam int unsigned BLINK_PERIOD = 800;
    localparam int unsigned CNT_W        = 10;
    localparam logic [CNT_W-1:0] BLINK_LAST = CNT_W'(BLINK_PERIOD);
    localparam logic [CNT_W-1:0] BLINK_HALF = CNT_W'(BLINK_PERIOD / 2);

    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 32;

    typedef enum logic [1:0] {
        FUNC_TICK = 2'd0,
        FUNC_DEC  = 2'd1,
        FUNC_HEX  = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        REG_BLINK_MASK  = 2'd0,
        REG_POINT_MASK  = 2'd1,
        REG_SCAN_ENABLE = 2'd2
    } reg_idx_t;

    localparam logic [7:0] SEG_BLANK = 8'hFF;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] value;
    } in_t;

    typedef struct packed {
        logic [7:0] segments;
        logic       shifted;
        logic       select_first;
        logic       select_second;
    } out_t;

    // Active-low segment pattern for one hex digit, bit 7 is the point
    function automatic logic [7:0] glyph(input logic [3:0] digit);
        logic [7:0] seg;
        case (digit)
            4'h0: seg = 8'hC0;
            4'h1: seg = 8'hF9;
            4'h2: seg = 8'hA4;
            4'h3: seg = 8'hB0;
            4'h4: seg = 8'h99;
            4'h5: seg = 8'h92;
            4'h6: seg = 8'h82;
            4'h7: seg = 8'hF8;
            4'h8: seg = 8'h80;
            4'h9: seg = 8'h90;
            4'hA: seg = 8'h88;
            4'hB: seg = 8'h83;
            4'hC: seg = 8'hC6;
            4'hD: seg = 8'hA1;
            4'hE: seg = 8'h86;
            4'hF: seg = 8'h8E;
            default: seg = SEG_BLANK;
        endcase
        return seg;
    endfunction

endpackage

// ----- rtl/two_digit_seven_segment_scanner.sv -----
// Two-digit seven-segment scanner: state, register port and output stage
//
// Takes one request per clock cycle: a scan tick, a decimal load or a hex
// load. Every request gives exactly one result, the cycle after it is taken,
// from the output register; the input side keeps accepting as long as that
// register is empty or being drained in the same cycle, so the sustained
// rate is one request per cycle. A load writes both digits and restarts the
// blink period. Each enabled tick serves one digit in turn, the second digit
// first, and drives its select line high with the active-low segment byte;
// a blinking digit is blanked in the second half of the blink period.
// Registers (APB, 32-bit): 0x0 blink mask, 0x4 point mask, 0x8 scan enable.
// Write registers only while no request is in flight.
module two_digit_seven_segment_scanner
    import tdss_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_t               s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_t              m_data
);

    logic [1:0]       blink_mask_reg;
    logic [1:0]       point_mask_reg;
    logic             scan_enable_reg;
    logic [3:0]       digit_reg [2];
    logic [CNT_W-1:0] blink_cnt_reg;
    logic             phase_reg;
    logic [1:0]       select_reg;
    logic [7:0]       last_seg_reg;
    logic             m_valid_reg;
    out_t             m_data_reg;

    logic [3:0]       digit_next [2];
    logic [CNT_W-1:0] blink_cnt_next;
    logic             phase_next;
    logic [1:0]       select_next;
    logic [7:0]       last_seg_next;
    logic             shifted_next;

    logic             s_fire;
    logic             cfg_wr;
    reg_idx_t         cfg_idx;
    logic [7:0]       dec_rem;
    logic [7:0]       dec_tens;
    logic [7:0]       dec_units;
    logic [15:0]      dec_prod;
    logic             serve_idx;
    logic [1:0]       own;
    logic             blank;
    logic [7:0]       seg;
    logic [CNT_W-1:0] cnt_inc;

    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        prdata = '0;
        case (cfg_idx)
            REG_BLINK_MASK:  prdata = DATA_W'(blink_mask_reg);
            REG_POINT_MASK:  prdata = DATA_W'(point_mask_reg);
            REG_SCAN_ENABLE: prdata = DATA_W'(scan_enable_reg);
            default:         prdata = '0;
        endcase
    end

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // value mod 100, then tens by reciprocal multiply (exact below 100)
    always_comb begin
        if (s_data.value >= 8'd200) begin
            dec_rem = s_data.value - 8'd200;
        end else if (s_data.value >= 8'd100) begin
            dec_rem = s_data.value - 8'd100;
        end else begin
            dec_rem = s_data.value;
        end
        dec_prod  = 16'(dec_rem) * 16'd205;
        dec_tens  = 8'(dec_prod >> 11);
        dec_units = dec_rem - 8'(dec_tens * 8'd10);
    end

    // phase low serves the second digit
    assign serve_idx = !phase_reg;
    assign own       = serve_idx ? 2'b10 : 2'b01;
    assign blank     = blink_mask_reg[serve_idx] && (blink_cnt_reg > BLINK_HALF);
    assign cnt_inc   = blink_cnt_reg + 1'b1;

    always_comb begin
        seg = glyph(digit_reg[serve_idx]);
        if (point_mask_reg[serve_idx]) begin
            seg[7] = 1'b0;
        end
    end

    always_comb begin
        digit_next[0]  = digit_reg[0];
        digit_next[1]  = digit_reg[1];
        blink_cnt_next = blink_cnt_reg;
        phase_next     = phase_reg;
        select_next    = select_reg;
        last_seg_next  = last_seg_reg;
        shifted_next   = 1'b0;
        case (func_t'(s_data.func))
            FUNC_TICK: begin
                if (scan_enable_reg) begin
                    if (blank) begin
                        select_next = select_reg & ~own;
                    end else begin
                        select_next   = own;
                        last_seg_next = seg;
                        shifted_next  = 1'b1;
                    end
                    blink_cnt_next = (cnt_inc == BLINK_LAST) ? '0 : cnt_inc;
                    phase_next     = !phase_reg;
                end
            end
            FUNC_DEC: begin
                blink_cnt_next = '0;
                digit_next[0]  = dec_tens[3:0];
                digit_next[1]  = dec_units[3:0];
            end
            FUNC_HEX: begin
                blink_cnt_next = '0;
                digit_next[0]  = s_data.value[7:4];
                digit_next[1]  = s_data.value[3:0];
            end
            default: begin
                // unknown function: leave state alone
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blink_mask_reg  <= '0;
            point_mask_reg  <= '0;
            scan_enable_reg <= 1'b1;
            digit_reg[0]    <= '0;
            digit_reg[1]    <= '0;
            blink_cnt_reg   <= '0;
            phase_reg       <= 1'b0;
            select_reg      <= '0;
            last_seg_reg    <= SEG_BLANK;
            m_valid_reg     <= 1'b0;
        end else begin
            if (s_fire) begin
                digit_reg[0]  <= digit_next[0];
                digit_reg[1]  <= digit_next[1];
                blink_cnt_reg <= blink_cnt_next;
                phase_reg     <= phase_next;
                select_reg    <= select_next;
                last_seg_reg  <= last_seg_next;
                m_valid_reg   <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_wr) begin
                case (cfg_idx)
                    REG_BLINK_MASK:  blink_mask_reg <= pwdata[1:0];
                    REG_POINT_MASK:  point_mask_reg <= pwdata[1:0];
                    REG_SCAN_ENABLE: begin
                        scan_enable_reg <= pwdata[0];
                        // disabling drops both select lines
                        if (!pwdata[0]) begin
                            select_reg <= '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_data_reg.segments      <= last_seg_next;
            m_data_reg.shifted       <= shifted_next;
            m_data_reg.select_first  <= select_next[0];
            m_data_reg.select_second <= select_next[1];
        end
    end

endmodule

// ----- rtl/tdss_checker.sv -----
// Port-level checker for the scanner and its bind
`include "two_digit_seven_segment_scanner_assert.svh"

module tdss_checker
    import tdss_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input out_t              m_data
);

    `TDSS_ASSERT_NOW(a_shift_one_select, aclk, aresetn, m_valid && m_data.shifted, $onehot({m_data.select_first, m_data.select_second}), "shifted result must light exactly one digit")
    `TDSS_ASSERT_NOW(a_never_both_selects, aclk, aresetn, m_valid, !(m_data.select_first && m_data.select_second), "both digit selects high")
    `TDSS_ASSERT_NOW(a_ready_when_free, aclk, aresetn, !m_valid || m_ready, s_ready, "request refused with output stage free")
    `TDSS_ASSERT_NEXT(a_stall_holds, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "stalled result changed")
    `TDSS_ASSERT_ALWAYS_NEXT(a_reset_empty, aclk, !aresetn, !m_valid, "result valid after reset")

endmodule

bind two_digit_seven_segment_scanner tdss_checker u_tdss_checker (.*);

// ----- tb/tb_top.sv -----
// Self-checking bench for the two-digit seven-segment scanner, shadow model and drivers
module tb_top;
    import tdss_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_LEN    = 200;
    localparam int PHASE_ITEMS = 35;
    localparam int SWEEP_ITEMS = 440;

    // Shadow copy of the scanner: registers, digit stores and pending frames
    class scanner_shadow;
        logic [1:0] blink_mask;
        logic [1:0] point_mask;
        logic       scan_on;
        logic [3:0] digits [2];
        logic [9:0] counter;
        logic       phase;
        logic [1:0] lines;
        logic [7:0] last_seg;
        logic [7:0] glyphs [16];
        out_t       pending_frames [$];
        int         faults;

        function new();
            glyphs = '{8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8,
                       8'h80, 8'h90, 8'h88, 8'h83, 8'hC6, 8'hA1, 8'h86, 8'h8E};
            blink_mask = 2'b00;
            point_mask = 2'b00;
            scan_on    = 1'b1;
            digits     = '{4'h0, 4'h0};
            counter    = '0;
            phase      = 1'b0;
            lines      = 2'b00;
            last_seg   = 8'hFF;
            faults     = 0;
        endfunction

        function void write_reg(reg_idx_t idx, logic [31:0] v);
            case (idx)
                REG_BLINK_MASK:  blink_mask = v[1:0];
                REG_POINT_MASK:  point_mask = v[1:0];
                REG_SCAN_ENABLE: begin
                    scan_on = v[0];
                    if (!v[0]) lines = 2'b00;
                end
                default: ;
            endcase
        endfunction

        function logic [31:0] read_reg(reg_idx_t idx);
            case (idx)
                REG_BLINK_MASK:  return 32'(blink_mask);
                REG_POINT_MASK:  return 32'(point_mask);
                REG_SCAN_ENABLE: return 32'(scan_on);
                default:         return 32'h0;
            endcase
        endfunction

        function void take_request(in_t req);
            out_t       frame;
            int         d;
            logic [7:0] seg;
            logic       sent;
            sent = 1'b0;
            case (req.func)
                FUNC_TICK: if (scan_on) begin
                    // phase low serves the second digit
                    d = phase ? 0 : 1;
                    if (blink_mask[d] && counter > BLINK_HALF) begin
                        lines[d] = 1'b0;
                    end else begin
                        seg = glyphs[digits[d]];
                        if (point_mask[d]) seg[7] = 1'b0;
                        last_seg     = seg;
                        sent         = 1'b1;
                        lines[1 - d] = 1'b0;
                        lines[d]     = 1'b1;
                    end
                    counter = counter + 10'd1;
                    if (counter == BLINK_LAST) counter = '0;
                    phase = ~phase;
                end
                FUNC_DEC: begin
                    counter   = '0;
                    digits[0] = 4'((req.value % 8'd100) / 8'd10);
                    digits[1] = 4'(req.value % 8'd10);
                end
                FUNC_HEX: begin
                    counter   = '0;
                    digits[0] = req.value[7:4];
                    digits[1] = req.value[3:0];
                end
                default: ;
            endcase
            frame.segments      = last_seg;
            frame.shifted       = sent;
            frame.select_first  = lines[0];
            frame.select_second = lines[1];
            pending_frames.push_back(frame);
        endfunction

        function void match_frame(out_t got);
            out_t want;
            if (pending_frames.size() == 0) begin
                faults++;
                $display("%0t: result %h with nothing pending", $time, got);
                return;
            end
            want = pending_frames.pop_front();
            if (got.segments !== want.segments) begin
                faults++;
                $display("%0t: segments expected %h got %h", $time, want.segments,
                         got.segments);
            end
            if (got.shifted !== want.shifted) begin
                faults++;
                $display("%0t: shifted expected %b got %b", $time, want.shifted, got.shifted);
            end
            if (got.select_first !== want.select_first) begin
                faults++;
                $display("%0t: select_first expected %b got %b", $time, want.select_first,
                         got.select_first);
            end
            if (got.select_second !== want.select_second) begin
                faults++;
                $display("%0t: select_second expected %b got %b", $time, want.select_second,
                         got.select_second);
            end
        endfunction
    endclass

    logic              aclk;
    logic              aresetn;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              s_valid;
    logic              s_ready;
    in_t               s_data;
    logic              m_valid;
    logic              m_ready;
    out_t              m_data;

    scanner_shadow shadow;
    int            send_idle_pct;
    int            stall_pct;
    bit            hold_req;
    int            idle_cycles;

    two_digit_seven_segment_scanner u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) shadow.match_frame(m_data);
            if (s_valid && s_ready) shadow.take_request(s_data);
            if (psel && penable && pwrite && pready)
                shadow.write_reg(reg_idx_t'(paddr[3:2]), pwdata);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel || !aresetn)
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, idle_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold-off when asked
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_LEN - 1) @(negedge aclk);
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic send_request(input logic [1:0] func, input logic [7:0] value);
        in_t req;
        req.func  = func;
        req.value = value;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic drain_and_settle();
        s_valid <= 1'b0;
        while (shadow.pending_frames.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // Write a register, then read it back
    task automatic set_reg(input reg_idx_t idx, input logic [31:0] v);
        logic [31:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        got = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== shadow.read_reg(idx)) begin
            shadow.faults++;
            $display("%0t: register %s read expected %h got %h", $time, idx.name(),
                     shadow.read_reg(idx), got);
        end
    endtask

    initial begin
        int         send_tab  [4];
        int         stall_tab [4];
        int         blink_tab [4];
        int         point_tab [4];
        int         scan_tab  [4];
        int         roll;
        logic [1:0] fn;

        send_tab  = '{0, 64, 0, 34};
        stall_tab = '{0, 0, 64, 34};
        blink_tab = '{0, 3, 2, 1};
        point_tab = '{0, 3, 1, 2};
        scan_tab  = '{1, 1, 0, 1};

        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_valid       = 1'b0;
        s_data        = '0;
        aresetn       = 1'b0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_req      = 1'b0;
        idle_cycles   = 0;
        shadow        = new();

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: reset view, both digits, value extremes, unknown code
        send_request(FUNC_UNUSED, 8'hFF);
        send_request(FUNC_TICK, 8'hFF);
        send_request(FUNC_TICK, 8'h00);
        send_request(FUNC_DEC, 8'd255);
        send_request(FUNC_TICK, 8'h5A);
        send_request(FUNC_TICK, 8'hA5);
        send_request(FUNC_DEC, 8'd99);
        send_request(FUNC_TICK, 8'h00);
        send_request(FUNC_TICK, 8'h00);
        send_request(FUNC_HEX, 8'hFF);
        send_request(FUNC_TICK, 8'h00);
        send_request(FUNC_TICK, 8'h00);
        send_request(FUNC_HEX, 8'hA5);
        send_request(FUNC_TICK, 8'hFF);
        send_request(FUNC_TICK, 8'hFF);
        send_request(FUNC_DEC, 8'd100);
        send_request(FUNC_TICK, 8'h00);
        send_request(FUNC_UNUSED, 8'h00);
        drain_and_settle();
        set_reg(REG_POINT_MASK, 32'd3);
        send_request(FUNC_TICK, 8'h00);
        send_request(FUNC_TICK, 8'h00);
        // Scanning off: ticks ignored, loads still land
        drain_and_settle();
        set_reg(REG_SCAN_ENABLE, 32'd0);
        send_request(FUNC_TICK, 8'h00);
        send_request(FUNC_HEX, 8'h3C);
        send_request(FUNC_TICK, 8'hFF);
        drain_and_settle();
        set_reg(REG_SCAN_ENABLE, 32'd1);
        send_request(FUNC_DEC, 8'd42);
        send_request(FUNC_TICK, 8'h00);

        for (int p = 0; p < 4; p++) begin
            drain_and_settle();
            send_idle_pct = send_tab[p];
            stall_pct     = stall_tab[p];
            set_reg(REG_BLINK_MASK, 32'(blink_tab[p]));
            set_reg(REG_POINT_MASK, 32'(point_tab[p]));
            set_reg(REG_SCAN_ENABLE, 32'(scan_tab[p]));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 0 && n == PHASE_ITEMS / 2) begin
                    // hold the result side while requests keep coming
                    s_valid <= 1'b0;
                    @(posedge aclk);
                    hold_req = 1'b1;
                    @(negedge aclk);
                end
                roll = $urandom_range(99);
                if (roll < 55)      fn = FUNC_TICK;
                else if (roll < 72) fn = FUNC_DEC;
                else if (roll < 89) fn = FUNC_HEX;
                else                fn = FUNC_UNUSED;
                send_request(fn, 8'($urandom_range(255)));
            end
        end

        // Long tick run: reach the blanked half of the blink period
        for (int s = 0; s < 1; s++) begin
            drain_and_settle();
            send_idle_pct = (s == 0) ? 34 : 0;
            stall_pct     = (s == 0) ? 34 : 0;
            set_reg(REG_BLINK_MASK, (s == 0) ? 32'd1 : 32'd3);
            set_reg(REG_POINT_MASK, (s == 0) ? 32'd2 : 32'd0);
            set_reg(REG_SCAN_ENABLE, 32'd1);
            send_request((s == 0) ? FUNC_DEC : FUNC_HEX, 8'($urandom_range(255)));
            for (int n = 0; n < SWEEP_ITEMS; n++) begin
                fn = ($urandom_range(99) < 95) ? FUNC_TICK : FUNC_UNUSED;
                send_request(fn, 8'($urandom_range(255)));
            end
        end

        drain_and_settle();
        repeat (8) @(posedge aclk);
        if (shadow.faults == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/tdss_pkg.sv
rtl/two_digit_seven_segment_scanner.sv
rtl/tdss_checker.sv
tb/tb_top.sv
